>>> design/lpet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpet_pkg
// Shared constants for the linear probing endpoint table: field widths,
// command and status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package lpet_pkg;

  localparam int KEY_W       = 64;
  localparam int VAL_W       = 64;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int N_CFG_W     = 13;
  localparam int LIM_CFG_W   = 7;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;

  localparam int DEF_TABLE_DEPTH     = 4096;
  localparam int DEF_MAX_PROBE_LIMIT = 64;

  localparam logic [N_CFG_W-1:0]   RST_SLOTS_IN_USE       = 13'd4096;
  localparam logic [LIM_CFG_W-1:0] RST_LOOKUP_PROBE_LIMIT = 7'd20;

  localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKUP_PROBE_LIMIT = 1'd1;

endpackage
`default_nettype wire

>>> design/linear_probe_endpoint_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_endpoint_table_top
// Open addressing key/value table with linear probing: insert, lookup, clear.
// ----------------------------------------------------------------------------
// Sequence: insert and lookup first form the key remainder (one bit a
//   cycle through the shared subtract/compare unit), then visit each probed
//   slot (registered memory read, then compare); immediate answers skip both.
// Clear sweeps every slot, one slot written per cycle.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset: sync, runs an empty sweep over every slot, busy high; no result stall.
module linear_probe_endpoint_table_top #(
  parameter int TABLE_DEPTH     = lpet_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_PROBE_LIMIT = lpet_pkg::DEF_MAX_PROBE_LIMIT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [lpet_pkg::CMD_W-1:0]     cmd,
  input  wire logic [lpet_pkg::KEY_W-1:0]     key,
  input  wire logic [lpet_pkg::VAL_W-1:0]     start_value,
  output logic                                done,
  output logic [lpet_pkg::STATUS_W-1:0]       status,
  output logic [lpet_pkg::VAL_W-1:0]          found_start,
  input  wire logic                           cfg_we,
  input  wire logic [lpet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lpet_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int NW  = $clog2(TABLE_DEPTH + 1);
  localparam int LW  = $clog2(MAX_PROBE_LIMIT + 1);
  localparam int MW  = (NW > lpet_pkg::N_CFG_W) ? NW : lpet_pkg::N_CFG_W;
  localparam int LMW = (LW > lpet_pkg::LIM_CFG_W) ? LW : lpet_pkg::LIM_CFG_W;
  localparam int CW  = (NW > LW) ? NW : LW;
  localparam int DCW = $clog2(lpet_pkg::KEY_W);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK
  } state_t;

  state_t state;

  logic [lpet_pkg::N_CFG_W-1:0]   slots_in_use;
  logic [lpet_pkg::LIM_CFG_W-1:0] lookup_probe_limit;

  logic [lpet_pkg::KEY_W-1:0] slot_keys   [TABLE_DEPTH];
  logic [lpet_pkg::VAL_W-1:0] slot_values [TABLE_DEPTH];
  logic [lpet_pkg::KEY_W-1:0] rd_key;
  logic [lpet_pkg::VAL_W-1:0] rd_val;

  logic [lpet_pkg::KEY_W-1:0] key_r;
  logic [lpet_pkg::KEY_W-1:0] key_rot;
  logic [lpet_pkg::VAL_W-1:0] val_r;
  logic                       is_insert;
  logic [NW-1:0]              n_r;
  logic [NW-1:0]              rem;
  logic [DCW-1:0]             div_cnt;
  logic [AW-1:0]              idx;
  logic [CW-1:0]              probe_cnt;
  logic [CW-1:0]              probe_max;
  logic [AW-1:0]              clr_addr;
  logic                       clr_report;

  logic [MW-1:0]  n_sat;
  logic [NW-1:0]  n_eff;
  logic [LMW-1:0] lim_sat;
  logic [LW-1:0]  lim_eff;
  logic [NW:0]    rem_sh;
  logic [NW:0]    rem_diff;
  logic [NW-1:0]  rem_next;
  logic [NW-1:0]  idx_inc;
  logic [AW-1:0]  idx_next;
  logic [CW-1:0]  probe_cnt_inc;
  logic           accept;

  logic                       key_we;
  logic [AW-1:0]              key_waddr;
  logic [lpet_pkg::KEY_W-1:0] key_wdata;
  logic                       val_we;

  // effective modulus and probe limit, saturated
  always_comb begin
    n_sat = (MW'(slots_in_use) > MW'(TABLE_DEPTH)) ? MW'(TABLE_DEPTH) : MW'(slots_in_use);
    n_eff = n_sat[NW-1:0];
    lim_sat = (LMW'(lookup_probe_limit) > LMW'(MAX_PROBE_LIMIT)) ?
              LMW'(MAX_PROBE_LIMIT) : LMW'(lookup_probe_limit);
    lim_eff = lim_sat[LW-1:0];
  end

  // restoring remainder step, one key bit per cycle
  always_comb begin
    rem_sh   = {rem, key_rot[lpet_pkg::KEY_W-1]};
    rem_diff = rem_sh - {1'b0, n_r};
    rem_next = (rem_sh >= {1'b0, n_r}) ? rem_diff[NW-1:0] : rem_sh[NW-1:0];
  end

  always_comb begin
    idx_inc       = NW'(idx) + NW'(1);
    idx_next      = (idx_inc == n_r) ? '0 : idx_inc[AW-1:0];
    probe_cnt_inc = probe_cnt + CW'(1);
  end

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // memory write port
  always_comb begin
    key_we    = 1'b0;
    key_waddr = clr_addr;
    key_wdata = lpet_pkg::EMPTY_KEY;
    val_we    = 1'b0;
    if (state == S_CLEAR) begin
      key_we = 1'b1;
    end else if (state == S_CHECK && is_insert && rd_key == lpet_pkg::EMPTY_KEY) begin
      key_we    = 1'b1;
      key_waddr = idx;
      key_wdata = key_r;
      val_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      slot_keys[key_waddr] <= key_wdata;
    end
    rd_key <= slot_keys[idx];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      slot_values[key_waddr] <= val_r;
    end
    rd_val <= slot_values[idx];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use       <= lpet_pkg::RST_SLOTS_IN_USE;
      lookup_probe_limit <= lpet_pkg::RST_LOOKUP_PROBE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        lpet_pkg::REG_SLOTS_IN_USE: begin
          slots_in_use <= cfg_data[lpet_pkg::N_CFG_W-1:0];
        end
        lpet_pkg::REG_LOOKUP_PROBE_LIMIT: begin
          lookup_probe_limit <= cfg_data[lpet_pkg::LIM_CFG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      done       <= 1'b0;
      idx        <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= S_IDLE;
            done     <= clr_report;
            if (clr_report) begin
              status      <= lpet_pkg::ST_CLEARED;
              found_start <= '0;
            end
          end else begin
            clr_addr <= clr_addr + AW'(1);
            done     <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            key_r       <= key;
            key_rot     <= key;
            val_r       <= start_value;
            n_r         <= n_eff;
            rem         <= '0;
            div_cnt     <= '0;
            probe_cnt   <= '0;
            found_start <= '0;
            case (cmd)
              lpet_pkg::CMD_INSERT: begin
                is_insert <= 1'b1;
                probe_max <= CW'(n_eff);
                if (n_eff == '0 || key == lpet_pkg::EMPTY_KEY) begin
                  done   <= 1'b1;
                  status <= lpet_pkg::ST_FULL;
                end else begin
                  done  <= 1'b0;
                  state <= S_DIV;
                end
              end
              lpet_pkg::CMD_LOOKUP: begin
                is_insert <= 1'b0;
                probe_max <= CW'(lim_eff);
                if (n_eff == '0 || key == lpet_pkg::EMPTY_KEY || lim_eff == '0) begin
                  done   <= 1'b1;
                  status <= lpet_pkg::ST_MISS;
                end else begin
                  done  <= 1'b0;
                  state <= S_DIV;
                end
              end
              lpet_pkg::CMD_CLEAR: begin
                done       <= 1'b0;
                clr_report <= 1'b1;
                clr_addr   <= '0;
                state      <= S_CLEAR;
              end
              default: begin
                done   <= 1'b1;
                status <= lpet_pkg::ST_MISS;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_DIV: begin
          done    <= 1'b0;
          rem     <= rem_next;
          key_rot <= {key_rot[lpet_pkg::KEY_W-2:0], key_rot[lpet_pkg::KEY_W-1]};
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(lpet_pkg::KEY_W - 1)) begin
            idx   <= rem_next[AW-1:0];
            state <= S_READ;
          end
        end
        S_READ: begin
          done  <= 1'b0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          probe_cnt <= probe_cnt_inc;
          if (is_insert && rd_key == lpet_pkg::EMPTY_KEY) begin
            done   <= 1'b1;
            status <= lpet_pkg::ST_STORED;
            state  <= S_IDLE;
          end else if (rd_key == key_r) begin
            done   <= 1'b1;
            state  <= S_IDLE;
            if (is_insert) begin
              status <= lpet_pkg::ST_PRESENT;
            end else begin
              status      <= lpet_pkg::ST_HIT;
              found_start <= rd_val;
            end
          end else if (probe_cnt_inc == probe_max) begin
            done   <= 1'b1;
            status <= is_insert ? lpet_pkg::ST_FULL : lpet_pkg::ST_MISS;
            state  <= S_IDLE;
          end else begin
            done  <= 1'b0;
            idx   <= idx_next;
            state <= S_READ;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == lpet_pkg::CMD_CLEAR |=> busy && clr_addr == '0)
    else $error("clear did not start a sweep");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= lpet_pkg::ST_CLEARED)
    else $error("status code out of range");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != lpet_pkg::ST_HIT |-> found_start == '0)
    else $error("found_start nonzero without hit");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> busy && !done)
    else $error("reset did not start the empty sweep");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> probe_cnt < probe_max && NW'(idx) < n_r)
    else $error("probe beyond limit or modulus");
`endif

endmodule
`default_nettype wire
